FILE: sv/assert_macros.svh
// Assertion macros used by the checker file of the heap queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bhq_pkg.sv
// Package with the shared types and constants of the binary min-heap queue.
package bhq_pkg;

  // Default sizes of the heap.
  localparam int unsigned DEPTH_DEF = 256;
  localparam int unsigned KEY_W_DEF = 32;

  // Width and reset value of the capacity register.
  localparam int unsigned CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Width of the operation and status codes.
  localparam int unsigned OP_W = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CHK,
    S_DN_CMP,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept_ins;
    logic    accept_rem;
    logic    up_issue;
    logic    up_move;
    logic    dn_load;
    logic    dn_issue;
    logic    dn_move;
    logic    place;
    logic    respond;
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic has_child;
    logic take;
  } stat_t;

endpackage

FILE: sv/bhq_controller.sv
// Controller state machine that sequences the sift steps of the heap queue.
module bhq_controller import bhq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [OP_W-1:0]     operation_i,
  input  stat_t               stat_i,
  output cmd_t                cmd_o,
  output logic                busy
);

  state_e  state_q, state_d;
  status_e res_q, res_d;
  op_e     op;

  assign op = op_e'(operation_i);

  // State and result code registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_DONE;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Next state and the status code of the beat being worked on.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d   = ST_DONE;
          state_d = S_RESP;
          case (op)
            OP_INSERT: begin
              if (stat_i.full) begin
                res_d = ST_FULL;
              end else begin
                state_d = S_UP_CHK;
              end
            end
            OP_REMOVE: begin
              if (stat_i.empty) begin
                res_d = ST_EMPTY;
              end else begin
                state_d = S_DN_LOAD;
              end
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_UP_CHK:  state_d = stat_i.pos_zero ? S_RESP : S_UP_CMP;
      S_UP_CMP:  state_d = stat_i.up_less ? S_UP_CHK : S_RESP;
      S_DN_LOAD: state_d = S_DN_CHK;
      S_DN_CHK:  state_d = stat_i.has_child ? S_DN_CMP : S_RESP;
      S_DN_CMP:  state_d = stat_i.take ? S_DN_CHK : S_RESP;
      S_RESP:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath for each state.
  always_comb begin
    cmd_o        = '0;
    cmd_o.status = res_q;
    busy         = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept_ins = (op == OP_INSERT) && !stat_i.full;
          cmd_o.accept_rem = (op == OP_REMOVE) && !stat_i.empty;
        end
      end
      S_UP_CHK: begin
        cmd_o.place    = stat_i.pos_zero;
        cmd_o.up_issue = !stat_i.pos_zero;
      end
      S_UP_CMP: begin
        cmd_o.up_move = stat_i.up_less;
        cmd_o.place   = !stat_i.up_less;
      end
      S_DN_LOAD: cmd_o.dn_load = 1'b1;
      S_DN_CHK: begin
        cmd_o.dn_issue = stat_i.has_child;
        cmd_o.place    = !stat_i.has_child;
      end
      S_DN_CMP: begin
        cmd_o.dn_move = stat_i.take;
        cmd_o.place   = !stat_i.take;
      end
      S_RESP:  cmd_o.respond = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

FILE: sv/bhq_datapath.sv
// Datapath of the heap queue: key store, sift registers, compares and result beat.
module bhq_datapath import bhq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_W_DEF,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic signed [KEY_WIDTH-1:0] key_value_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CAP_W-1:0]            cfg_data_i,
  input  cmd_t                        cmd_i,
  output stat_t                       stat_o,
  output logic [STATUS_W-1:0]         status_o,
  output logic signed [KEY_WIDTH-1:0] min_value_o,
  output logic                        min_valid_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic                        result_valid_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned IW   = AW + 2;
  localparam int unsigned CmpW = (CntW > CAP_W) ? CntW : CAP_W;

  logic signed [KEY_WIDTH-1:0] mem [DEPTH];

  logic [CAP_W-1:0]            cap_q;
  logic [CntW-1:0]             count_q;
  logic [AW-1:0]               pos_q;
  logic signed [KEY_WIDTH-1:0] key_q;
  logic signed [KEY_WIDTH-1:0] root_q;
  logic signed [KEY_WIDTH-1:0] rd_a_q, rd_b_q;
  logic [STATUS_W-1:0]         out_status_q;
  logic signed [KEY_WIDTH-1:0] out_min_q;
  logic                        out_valid_q;
  logic [CntW-1:0]             out_count_q;
  logic                        res_valid_q;

  logic [AW-1:0]               parent_idx;
  logic [IW-1:0]               child_l, child_r, n_ext;
  logic                        has_l, has_r, sel_right;
  logic signed [KEY_WIDTH-1:0] sel_val, wr_data;
  logic [AW-1:0]               sel_idx, rd_a_addr;
  logic                        wr_en, rd_en;
  logic [CmpW-1:0]             cap_eff;

  // Tree neighbors of the current hole.
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign child_l    = IW'({pos_q, 1'b1});
  assign child_r    = child_l + IW'(1);
  assign n_ext      = IW'(count_q);
  assign has_l      = child_l < n_ext;
  assign has_r      = child_r < n_ext;

  // Smaller child, the left one on a tie.
  assign sel_right = has_r && (rd_b_q < rd_a_q);
  assign sel_val   = sel_right ? rd_b_q : rd_a_q;
  assign sel_idx   = sel_right ? child_r[AW-1:0] : child_l[AW-1:0];

  // Capacity saturates at the store depth.
  assign cap_eff = (CmpW'(cap_q) > CmpW'(DEPTH)) ? CmpW'(DEPTH) : CmpW'(cap_q);

  assign stat_o.full      = CmpW'(count_q) >= cap_eff;
  assign stat_o.empty     = count_q == '0;
  assign stat_o.pos_zero  = pos_q == '0;
  assign stat_o.up_less   = key_q < rd_a_q;
  assign stat_o.has_child = has_l;
  assign stat_o.take      = sel_val < key_q;

  // Store port selection: one write at the hole, reads at parent, children or tail.
  assign wr_en   = cmd_i.place || cmd_i.up_move || cmd_i.dn_move;
  assign wr_data = cmd_i.place ? key_q : (cmd_i.up_move ? rd_a_q : sel_val);
  assign rd_en   = cmd_i.accept_rem || cmd_i.up_issue || cmd_i.dn_issue;

  always_comb begin
    rd_a_addr = child_l[AW-1:0];
    if (cmd_i.accept_rem) begin
      rd_a_addr = AW'(count_q - CntW'(1));
    end else if (cmd_i.up_issue) begin
      rd_a_addr = parent_idx;
    end
  end

  // Key store with registered reads.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[child_r[AW-1:0]];
    end
  end

  // Control registers: capacity, count and the result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.accept_ins) begin
        count_q <= count_q + CntW'(1);
      end else if (cmd_i.accept_rem) begin
        count_q <= count_q - CntW'(1);
      end
      res_valid_q <= cmd_i.respond;
    end
  end

  // Sift registers, the root copy and the result beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_ins) begin
      key_q <= key_value_i;
      pos_q <= AW'(count_q);
    end else if (cmd_i.accept_rem) begin
      pos_q <= '0;
    end else if (cmd_i.dn_load) begin
      key_q <= rd_a_q;
    end else if (cmd_i.up_move) begin
      pos_q <= parent_idx;
    end else if (cmd_i.dn_move) begin
      pos_q <= sel_idx;
    end
    if (wr_en && (pos_q == '0)) begin
      root_q <= wr_data;
    end
    if (cmd_i.respond) begin
      out_status_q <= cmd_i.status;
      out_valid_q  <= count_q != '0;
      out_min_q    <= (count_q != '0) ? root_q : '0;
      out_count_q  <= count_q;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign status_o       = out_status_q;
  assign min_value_o    = out_min_q;
  assign min_valid_o    = out_valid_q;
  assign entry_count_o  = out_count_q;
  assign result_valid_o = res_valid_q;

endmodule

FILE: sv/binary_min_heap_queue_unit.sv
// Peek and refused items: the result strobe follows acceptance through the S_RESP state and
// the result register. Insert: per level climbed, a parent read, then a compare and write;
// remove: one read of the tail key, then per level sunk a read of both children, a compare
// and a write. One item at a time; the next enters with the result.
// Reset empties the heap and sets the capacity to 256; stored keys are not cleared.
// Each result is presented for one cycle only; the receiver cannot stall it.
module binary_min_heap_queue_unit import bhq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_W_DEF,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             operation_i,
  input  logic signed [KEY_WIDTH-1:0] key_value_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CAP_W-1:0]            cfg_data_i,
  output logic [STATUS_W-1:0]         status_o,
  output logic signed [KEY_WIDTH-1:0] min_value_o,
  output logic                        min_valid_o,
  output logic [CntW-1:0]             entry_count_o,
  output logic                        result_valid_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  bhq_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  // Store and compare logic.
  bhq_datapath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_value_i    (key_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (status_o),
    .min_value_o    (min_value_o),
    .min_valid_o    (min_valid_o),
    .entry_count_o  (entry_count_o),
    .result_valid_o (result_valid_o)
  );

endmodule

FILE: sv/bhq_checker.sv
// Port-level checker for the heap queue and its bind to the top level.
`include "assert_macros.svh"

module bhq_checker import bhq_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_W_DEF,
  localparam int unsigned CntW     = $clog2(DEPTH + 1)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [STATUS_W-1:0]         status_o,
  input logic signed [KEY_WIDTH-1:0] min_value_o,
  input logic                        min_valid_o,
  input logic [CntW-1:0]             entry_count_o,
  input logic                        result_valid_o
);

  // The valid flag agrees with the reported count.
  `BHQ_ASSERT_SAME(a_valid_count, result_valid_o, min_valid_o == (entry_count_o != '0), "min_valid disagrees with entry_count")

  // An empty heap reports a zero minimum.
  `BHQ_ASSERT_SAME(a_empty_zero, result_valid_o && !min_valid_o, min_value_o == '0, "empty heap shows a nonzero minimum")

  // A remove refused as empty leaves the count at zero.
  `BHQ_ASSERT_SAME(a_empty_count, result_valid_o && (status_o == ST_EMPTY), entry_count_o == '0, "empty refusal with keys held")

  // An accepted beat keeps the block busy in the next cycle.
  `BHQ_ASSERT_NEXT(a_busy_after, start && !busy, busy, "busy did not rise after a beat")

  // Result strobes never come in back-to-back cycles.
  `BHQ_ASSERT_NEXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe held two cycles")

endmodule

bind binary_min_heap_queue_unit bhq_checker #(
  .DEPTH     (DEPTH),
  .KEY_WIDTH (KEY_WIDTH)
) u_bhq_checker (.*);

FILE: sim/binary_min_heap_queue_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the binary min-heap queue unit with its own heap predictor.
module binary_min_heap_queue_unit_tb;
  import bhq_pkg::*;

  localparam int unsigned HEAP_DEPTH   = DEPTH_DEF;
  localparam int unsigned KEY_W        = KEY_W_DEF;
  localparam int unsigned COUNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int          RANDOM_OPS   = 1700;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          DRAIN_CYCLES = 30;
  localparam int          PRINT_LIMIT  = 50;

  // Operation code 3 has no name in the package; the block treats it as a peek.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  // One beat waiting to be driven: either an operation or a capacity write.
  typedef struct {
    bit                       is_cap_write;
    logic [OP_W-1:0]          op;
    logic signed [KEY_W-1:0]  key;
    logic [CAP_W-1:0]         cap;
  } heap_beat_t;

  // What the block must report for one operation.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    min_key;
    logic                min_valid;
    logic [COUNT_W-1:0]  count;
  } heap_result_t;

  logic                       clk_i = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start_q = 1'b0;
  logic [OP_W-1:0]            op_q = OP_PEEK;
  logic signed [KEY_W-1:0]    key_q = '0;
  logic                       cap_valid_q = 1'b0;
  logic [CAP_W-1:0]           cap_data_q = '0;
  logic                       busy;
  logic                       cap_ready;
  logic [STATUS_W-1:0]        status;
  logic signed [KEY_W-1:0]    min_value;
  logic                       min_valid;
  logic [COUNT_W-1:0]         entry_count;
  logic                       result_valid;

  binary_min_heap_queue_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .start          (start_q),
    .busy           (busy),
    .operation_i    (op_q),
    .key_value_i    (key_q),
    .cfg_valid_i    (cap_valid_q),
    .cfg_ready_o    (cap_ready),
    .cfg_data_i     (cap_data_q),
    .status_o       (status),
    .min_value_o    (min_value),
    .min_valid_o    (min_valid),
    .entry_count_o  (entry_count),
    .result_valid_o (result_valid)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the heap array, its fill level and the capacity register.
  logic signed [KEY_W-1:0] heap_keys [HEAP_DEPTH];
  int                      heap_fill = 0;
  logic [CAP_W-1:0]        capacity = CAP_RESET;

  heap_beat_t   pending_beats [$];
  heap_result_t expected_results [$];

  int err_count = 0;
  int checked_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int calm_left = 0;
  int n_insert = 0;
  int n_remove = 0;
  int n_peek = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_cap_writes = 0;
  int peak_fill = 0;

  // Apply one operation to the predictor heap and return what the block must report.
  function automatic heap_result_t heap_apply(input logic [OP_W-1:0] op,
                                              input logic signed [KEY_W-1:0] key);
    heap_result_t            res;
    int                      limit;
    int                      pos;
    int                      parent;
    int                      child;
    logic signed [KEY_W-1:0] tmp;
    res.status = ST_DONE;
    limit = (capacity > HEAP_DEPTH) ? HEAP_DEPTH : int'(capacity);
    if (op == OP_INSERT) begin
      n_insert++;
      if (heap_fill >= limit) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        // Append at the end and climb while smaller than the parent.
        heap_keys[heap_fill] = key;
        pos = heap_fill;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (!(heap_keys[pos] < heap_keys[parent])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[parent];
          heap_keys[parent] = tmp;
          pos = parent;
        end
        heap_fill++;
      end
    end else if (op == OP_REMOVE) begin
      n_remove++;
      if (heap_fill == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        // Move the last key to the root and sink it, taking the left child on a tie.
        heap_keys[0] = heap_keys[heap_fill - 1];
        heap_fill--;
        pos = 0;
        child = 1;
        while (child < heap_fill) begin
          if (child + 1 < heap_fill && heap_keys[child + 1] < heap_keys[child]) child++;
          if (!(heap_keys[child] < heap_keys[pos])) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[child];
          heap_keys[child] = tmp;
          pos = child;
          child = 2 * pos + 1;
        end
      end
    end else begin
      n_peek++;
    end
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    res.min_key   = (heap_fill > 0) ? heap_keys[0] : '0;
    res.min_valid = (heap_fill > 0);
    res.count     = heap_fill[COUNT_W-1:0];
    return res;
  endfunction

  // Idle cycles before the next beat: mostly none or short, a few long, with calm stretches.
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < PRINT_LIMIT) $display("%0t ERROR: %s", $time, what);
    err_count++;
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key);
    heap_beat_t b;
    b.is_cap_write = 1'b0;
    b.op = op;
    b.key = key;
    b.cap = '0;
    pending_beats.push_back(b);
  endtask

  task automatic queue_cap(input logic [CAP_W-1:0] cap);
    heap_beat_t b;
    b.is_cap_write = 1'b1;
    b.op = OP_PEEK;
    b.key = '0;
    b.cap = cap;
    pending_beats.push_back(b);
  endtask

  // Random key: full range mostly, small values for duplicates, and the extremes.
  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return KEY_MAX;
          1: return KEY_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return KEY_W'(int'($urandom_range(0, 15)) - 8);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  // Driver: one beat at a time, operations on start/busy, capacity writes only when idle.
  always @(posedge clk_i) begin : drive_proc
    heap_beat_t b;
    logic       finished;
    if (rst_n) begin
      finished = 1'b0;
      if (start_q && !busy) begin
        expected_results.push_back(heap_apply(op_q, key_q));
        finished = 1'b1;
      end
      if (cap_valid_q && cap_ready) begin
        capacity = cap_data_q;
        n_cap_writes++;
        finished = 1'b1;
      end
      if (finished) gap_left = next_gap();
      if (finished || (!start_q && !cap_valid_q)) begin
        if (gap_left > 0) begin
          gap_left--;
          start_q <= 1'b0;
          cap_valid_q <= 1'b0;
        end else if (pending_beats.size() > 0 && !pending_beats[0].is_cap_write) begin
          b = pending_beats.pop_front();
          start_q <= 1'b1;
          op_q <= b.op;
          key_q <= b.key;
          cap_valid_q <= 1'b0;
        end else if (pending_beats.size() > 0 && expected_results.size() == 0 && !busy) begin
          b = pending_beats.pop_front();
          start_q <= 1'b0;
          cap_valid_q <= 1'b1;
          cap_data_q <= b.cap;
        end else begin
          start_q <= 1'b0;
          cap_valid_q <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_proc
    heap_result_t want;
    if (rst_n && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result strobe with no operation outstanding");
      end else begin
        want = expected_results.pop_front();
        checked_count++;
        if (status !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    checked_count, status, want.status));
        if (min_valid !== want.min_valid)
          report_mismatch($sformatf("result %0d min_valid %0b, expected %0b",
                                    checked_count, min_valid, want.min_valid));
        if (min_value !== want.min_key)
          report_mismatch($sformatf("result %0d min_value %0d, expected %0d",
                                    checked_count, min_value, $signed(want.min_key)));
        if (entry_count !== want.count)
          report_mismatch($sformatf("result %0d entry_count %0d, expected %0d",
                                    checked_count, entry_count, want.count));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("binary_min_heap_queue_unit verification failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int made;
    int span;
    int mix;
    int r;
    int phase;
    logic [OP_W-1:0] op;

    // Directed: empty heap cases, extreme and equal keys, unused code.
    queue_op(OP_PEEK, '0);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_UNUSED, KEY_MAX);
    queue_op(OP_INSERT, KEY_MAX);
    queue_op(OP_INSERT, KEY_MIN);
    queue_op(OP_INSERT, '0);
    queue_op(OP_INSERT, '1);
    queue_op(OP_INSERT, 5);
    queue_op(OP_INSERT, 5);
    queue_op(OP_INSERT, 5);
    queue_op(OP_UNUSED, '1);
    queue_op(OP_PEEK, KEY_MIN);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_REMOVE, '0);
    // Capacity lowered below the count: inserts refused until removes make room.
    queue_cap(9'd2);
    queue_op(OP_INSERT, 1);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_INSERT, 2);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_INSERT, 3);
    // Capacity zero refuses every insert; then drain to an empty remove.
    queue_cap(9'd0);
    queue_op(OP_INSERT, 4);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_REMOVE, '0);
    queue_op(OP_REMOVE, '0);
    queue_cap(9'd1);
    queue_op(OP_INSERT, 9);
    queue_op(OP_INSERT, -9);

    // Random phases: each has a capacity and a leaning toward filling, draining or mixing.
    made = 0;
    phase = 0;
    while (made < RANDOM_OPS) begin
      if (phase == 0) begin
        // Capacity above the depth saturates; fill until the store itself is full.
        queue_cap(9'd511);
        span = 330;
        mix = 3;
      end else begin
        case ($urandom_range(0, 7))
          0: queue_cap(9'd0);
          1: queue_cap(CAP_W'($urandom_range(1, 4)));
          2: queue_cap(CAP_W'($urandom_range(5, 40)));
          3: queue_cap(CAP_W'($urandom_range(41, 255)));
          4: queue_cap(CAP_RESET);
          5: queue_cap(CAP_W'($urandom_range(257, 511)));
          default: ;
        endcase
        span = $urandom_range(40, 140);
        mix = $urandom_range(0, 2);
      end
      for (int i = 0; i < span && made < RANDOM_OPS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 2) op = OP_UNUSED;
        else if (r < 10) op = OP_PEEK;
        else if (mix == 0) op = (r < 88) ? OP_INSERT : OP_REMOVE;
        else if (mix == 1) op = (r < 28) ? OP_INSERT : OP_REMOVE;
        else if (mix == 2) op = (r < 55) ? OP_INSERT : OP_REMOVE;
        else op = (r < 97) ? OP_INSERT : OP_REMOVE;
        queue_op(op, rand_key());
        made++;
      end
      phase++;
    end

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_beats.size() > 0 || start_q || cap_valid_q || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations (%0d insert, %0d remove, %0d peek) with %0d capacity writes.",
             checked_count, n_insert, n_remove, n_peek, n_cap_writes);
    $display("Inserts refused as full: %0d, removes refused as empty: %0d, deepest heap: %0d.",
             n_full, n_empty, peak_fill);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("binary_min_heap_queue_unit verification clean");
    end else begin
      $display("binary_min_heap_queue_unit verification failed");
    end
    $finish;
  end

endmodule
